FILE: rtl/rps_pkg.sv
// Shared types, codes and constants of the reflow profile sequencer.
package rps_pkg;

  // Time base and fan run-on length, in ticks
  localparam int unsigned TICKS_PER_SECOND = 1000;
  localparam int unsigned FAN_RUNON_TICKS  = 120000;

  localparam logic [9:0]  SECOND_TICKS_10 = 10'(TICKS_PER_SECOND);
  localparam logic [19:0] SECOND_TICKS_20 = 20'(TICKS_PER_SECOND);
  localparam logic [16:0] RUNON_TICKS     = 17'(FAN_RUNON_TICKS);

  // Fan run-on starts on a stop or at the end of cooldown above 50 degrees (quarter degrees)
  localparam logic signed [15:0] HOT_Q = 16'sd200;

  // Windows around the soak target and the setpoint, and the soak creep step, quarter degrees
  localparam logic signed [15:0] SOAK_BAND_Q = 16'sd8;
  localparam logic signed [15:0] STEP_BAND_Q = 16'sd12;
  localparam logic signed [15:0] CREEP_Q     = 16'sd4;

  // Configuration register indexes
  localparam logic [2:0] CFG_FIXED_TEMP    = 3'd0;
  localparam logic [2:0] CFG_SOAK_TIME_S   = 3'd1;
  localparam logic [2:0] CFG_SOAK_TEMP     = 3'd2;
  localparam logic [2:0] CFG_SOAK_TEMP_MAX = 3'd3;
  localparam logic [2:0] CFG_REFLOW_TIME_S = 3'd4;
  localparam logic [2:0] CFG_REFLOW_TEMP   = 3'd5;
  localparam logic [2:0] CFG_PEAK_TEMP     = 3'd6;
  localparam logic [2:0] CFG_SOAK_RATE     = 3'd7;

  typedef enum logic [2:0] {
    KIND_TICK        = 3'd0,
    KIND_SAMPLE      = 3'd1,
    KIND_START_RAMP  = 3'd2,
    KIND_START_FIXED = 3'd3,
    KIND_STOP        = 3'd4
  } kind_e;

  typedef enum logic [2:0] {
    PH_IDLE      = 3'd0,
    PH_INIT      = 3'd1,
    PH_RAMP_SOAK = 3'd2,
    PH_SOAKING   = 3'd3,
    PH_RAMP_PEAK = 3'd4,
    PH_REFLOW    = 3'd5,
    PH_COOLDOWN  = 3'd6
  } phase_e;

  typedef struct packed {
    logic [9:0] fixed_temp;
    logic [9:0] soak_time_s;
    logic [9:0] soak_temp;
    logic [9:0] soak_temp_max;
    logic [9:0] reflow_time_s;
    logic [9:0] reflow_temp;
    logic [9:0] peak_temp;
    logic [3:0] soak_rate;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    fixed_temp:    10'd100,
    soak_time_s:   10'd90,
    soak_temp:     10'd100,
    soak_temp_max: 10'd140,
    reflow_time_s: 10'd100,
    reflow_temp:   10'd183,
    peak_temp:     10'd235,
    soak_rate:     4'd3
  };

  typedef struct packed {
    logic signed [13:0] actual_temp;
    logic signed [13:0] last_temp;
    logic signed [14:0] temp_rate;
    logic signed [13:0] setpoint_reg;
    phase_e             phase_reg;
    logic               running_flag;
    logic               fixed_flag;
    logic               fan_flag;
    logic [9:0]         step_timer;
    logic [19:0]        phase_timer;
    logic [9:0]         rate_timer;
    logic [16:0]        runon_timer;
    logic               runon_armed;
  } state_t;

endpackage

FILE: rtl/reflow_profile_sequencer.sv
// Top level of the reflow profile sequencer: configuration, state and result handshake.
//
// Takes one item per clock cycle unless a waiting result is not taken, and returns
// one result per item, in the cycle after it is accepted. The whole update for an
// item (timers, rate of change, fan run-on and the phase step) is a single pass of
// compares and adds from the state register back into it; the state register
// doubles as the result register, so a new item is taken in the same cycle a
// waiting result is taken. Results show the state after their item. Configuration
// writes take effect at once and are meant for times when no result is pending.
module reflow_profile_sequencer (
  input  logic               clk_i,
  input  logic               rst_ni,
  // Configuration writes
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [9:0]         cfg_wdata_i,
  // Input items
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [2:0]         kind_i,
  input  logic signed [13:0] temp_q_i,
  // Result items
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [13:0] setpoint_q_o,
  output logic [2:0]         phase_o,
  output logic               running_o,
  output logic               fixed_mode_o,
  output logic               fan_on_o,
  output logic signed [14:0] rate_q_o
);

  rps_pkg::cfg_t   cfg_q;
  rps_pkg::state_t st_q;
  rps_pkg::state_t st_d;
  logic            out_valid_q;
  logic            in_fire;

  // Accept whenever the result slot is free or being emptied
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_fire    = in_valid_i && in_ready_o;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= rps_pkg::CFG_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        rps_pkg::CFG_FIXED_TEMP:    cfg_q.fixed_temp    <= cfg_wdata_i;
        rps_pkg::CFG_SOAK_TIME_S:   cfg_q.soak_time_s   <= cfg_wdata_i;
        rps_pkg::CFG_SOAK_TEMP:     cfg_q.soak_temp     <= cfg_wdata_i;
        rps_pkg::CFG_SOAK_TEMP_MAX: cfg_q.soak_temp_max <= cfg_wdata_i;
        rps_pkg::CFG_REFLOW_TIME_S: cfg_q.reflow_time_s <= cfg_wdata_i;
        rps_pkg::CFG_REFLOW_TEMP:   cfg_q.reflow_temp   <= cfg_wdata_i;
        rps_pkg::CFG_PEAK_TEMP:     cfg_q.peak_temp     <= cfg_wdata_i;
        rps_pkg::CFG_SOAK_RATE:     cfg_q.soak_rate     <= cfg_wdata_i[3:0];
      endcase
    end
  end

  // Next state for the item at the input
  rps_step u_step (
    .kind_i   (kind_i),
    .temp_q_i (temp_q_i),
    .cfg_i    (cfg_q),
    .st_i     (st_q),
    .st_o     (st_d)
  );

  // Advance the state on each accepted item; hold it while the result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_fire) begin
        st_q <= st_d;
      end
      if (in_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Results show the state after their item
  assign out_valid_o  = out_valid_q;
  assign setpoint_q_o = st_q.setpoint_reg;
  assign phase_o      = st_q.phase_reg;
  assign running_o    = st_q.running_flag;
  assign fixed_mode_o = st_q.fixed_flag;
  assign fan_on_o     = st_q.fan_flag;
  assign rate_q_o     = st_q.temp_rate;

endmodule

FILE: rtl/rps_step.sv
// Next-state logic of the sequencer for one item.
module rps_step (
  input  logic [2:0]          kind_i,
  input  logic signed [13:0]  temp_q_i,
  input  rps_pkg::cfg_t       cfg_i,
  input  rps_pkg::state_t     st_i,
  output rps_pkg::state_t     st_o
);

  logic [9:0]         step_inc;
  logic [9:0]         rate_inc;
  logic [19:0]        phase_inc;
  logic [16:0]        runon_inc;
  logic signed [15:0] act_w;
  logic signed [15:0] sp_w;
  logic signed [15:0] soak_w;
  logic signed [15:0] soak_max_w;
  logic signed [15:0] rate_w;
  logic signed [15:0] reflow_w;
  logic signed [15:0] peak_w;
  logic signed [14:0] diff_w;
  logic [19:0]        soak_ticks;
  logic [19:0]        reflow_ticks;
  logic               hot;
  logic               in_band;
  logic               near_sp;
  logic               sp_can_rise;
  logic               step_due;

  // Saturating timer increments
  assign step_inc  = (st_i.step_timer == '1) ? st_i.step_timer : st_i.step_timer + 10'd1;
  assign rate_inc  = (st_i.rate_timer == '1) ? st_i.rate_timer : st_i.rate_timer + 10'd1;
  assign phase_inc = (st_i.phase_timer == '1) ? st_i.phase_timer
                                               : st_i.phase_timer + 20'd1;
  assign runon_inc = (st_i.runon_timer == '1) ? st_i.runon_timer
                                               : st_i.runon_timer + 17'd1;

  // Widen everything to quarter degrees on a common signed width
  assign act_w      = $signed({{2{st_i.actual_temp[13]}}, st_i.actual_temp});
  assign sp_w       = $signed({{2{st_i.setpoint_reg[13]}}, st_i.setpoint_reg});
  assign soak_w     = $signed({4'd0, cfg_i.soak_temp, 2'd0});
  assign soak_max_w = $signed({4'd0, cfg_i.soak_temp_max, 2'd0});
  assign rate_w     = $signed({10'd0, cfg_i.soak_rate, 2'd0});
  assign reflow_w   = $signed({4'd0, cfg_i.reflow_temp, 2'd0});
  assign peak_w     = $signed({4'd0, cfg_i.peak_temp, 2'd0});

  assign diff_w = $signed({st_i.actual_temp[13], st_i.actual_temp})
                - $signed({st_i.last_temp[13], st_i.last_temp});

  // Phase lengths in ticks
  assign soak_ticks   = 20'(cfg_i.soak_time_s) * rps_pkg::SECOND_TICKS_20;
  assign reflow_ticks = 20'(cfg_i.reflow_time_s) * rps_pkg::SECOND_TICKS_20;

  assign hot         = act_w > rps_pkg::HOT_Q;
  assign in_band     = (act_w >= soak_w - rps_pkg::SOAK_BAND_Q) &&
                       (act_w <= soak_w + rps_pkg::SOAK_BAND_Q);
  assign near_sp     = (act_w >= sp_w - rps_pkg::STEP_BAND_Q) &&
                       (act_w <= sp_w + rps_pkg::STEP_BAND_Q);
  assign sp_can_rise = sp_w < (soak_w - rate_w);
  assign step_due    = step_inc >= rps_pkg::SECOND_TICKS_10;

  always_comb begin
    st_o = st_i;
    unique case (kind_i)
      rps_pkg::KIND_TICK: begin
        // Advance timers
        st_o.step_timer  = step_inc;
        st_o.phase_timer = phase_inc;
        st_o.rate_timer  = rate_inc;
        // Once a second, latch the rate of change
        if (rate_inc >= rps_pkg::SECOND_TICKS_10) begin
          st_o.temp_rate  = diff_w;
          st_o.last_temp  = st_i.actual_temp;
          st_o.rate_timer = '0;
        end
        // Fan run-on count
        if (st_i.runon_armed) begin
          if (!st_i.running_flag && st_i.runon_timer >= rps_pkg::RUNON_TICKS) begin
            st_o.fan_flag    = 1'b0;
            st_o.runon_armed = 1'b0;
            st_o.runon_timer = '0;
          end else begin
            st_o.runon_timer = runon_inc;
          end
        end
        // Setpoint sequencing
        if (st_i.running_flag) begin
          if (st_i.fixed_flag) begin
            st_o.setpoint_reg = $signed({2'd0, cfg_i.fixed_temp, 2'd0});
          end else begin
            case (st_i.phase_reg)
              rps_pkg::PH_INIT: begin
                st_o.phase_reg    = rps_pkg::PH_RAMP_SOAK;
                st_o.step_timer   = '0;
                st_o.setpoint_reg = st_i.actual_temp;
              end
              rps_pkg::PH_RAMP_SOAK: begin
                if (in_band) begin
                  st_o.phase_reg   = rps_pkg::PH_SOAKING;
                  st_o.phase_timer = '0;
                end else if (step_due) begin
                  st_o.step_timer = '0;
                  if (sp_can_rise && near_sp) begin
                    st_o.setpoint_reg = 14'(sp_w + rate_w);
                  end
                end
              end
              rps_pkg::PH_SOAKING: begin
                if (phase_inc >= soak_ticks) begin
                  st_o.setpoint_reg = $signed({2'd0, cfg_i.peak_temp, 2'd0});
                  st_o.phase_reg    = rps_pkg::PH_RAMP_PEAK;
                end else if (step_due) begin
                  st_o.step_timer = '0;
                  if (sp_w < soak_max_w) begin
                    st_o.setpoint_reg = 14'(sp_w + rps_pkg::CREEP_Q);
                  end
                end
              end
              rps_pkg::PH_RAMP_PEAK: begin
                if (act_w >= reflow_w) begin
                  st_o.phase_timer = '0;
                  st_o.phase_reg   = rps_pkg::PH_REFLOW;
                end
              end
              rps_pkg::PH_REFLOW: begin
                if (act_w >= peak_w) begin
                  st_o.setpoint_reg = $signed({2'd0, cfg_i.reflow_temp, 2'd0});
                end
                if (phase_inc >= reflow_ticks) begin
                  st_o.phase_reg = rps_pkg::PH_COOLDOWN;
                end
              end
              rps_pkg::PH_COOLDOWN: begin
                // Stop the run and drop back to idle; above 50 degrees, start the fan run-on
                st_o.running_flag = 1'b0;
                st_o.phase_reg    = rps_pkg::PH_IDLE;
                st_o.setpoint_reg = '0;
                if (hot) begin
                  st_o.fan_flag    = 1'b1;
                  st_o.runon_armed = 1'b1;
                  st_o.runon_timer = '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
      end
      rps_pkg::KIND_SAMPLE: begin
        st_o.actual_temp = temp_q_i;
      end
      rps_pkg::KIND_START_RAMP: begin
        if (!st_i.running_flag) begin
          st_o.running_flag = 1'b1;
          st_o.phase_reg    = rps_pkg::PH_INIT;
          st_o.fixed_flag   = 1'b0;
        end
      end
      rps_pkg::KIND_START_FIXED: begin
        if (!st_i.running_flag) begin
          st_o.running_flag = 1'b1;
          st_o.fixed_flag   = 1'b1;
          st_o.fan_flag     = 1'b1;
        end
      end
      rps_pkg::KIND_STOP: begin
        st_o.running_flag = 1'b0;
        st_o.phase_reg    = rps_pkg::PH_INIT;
        st_o.setpoint_reg = '0;
        if (hot) begin
          st_o.fan_flag    = 1'b1;
          st_o.runon_armed = 1'b1;
          st_o.runon_timer = '0;
        end
      end
      default: begin
      end
    endcase
  end

endmodule
